// ----- rtl/core/int8_block_scaled_dot_accumulator_macros.svh -----
// Assertion macros for the block-scaled int8 dot accumulator.
// Included by the modules that carry concurrent assertions.
`ifndef INT8_BLOCK_SCALED_DOT_ACCUMULATOR_MACROS_SVH
`define INT8_BLOCK_SCALED_DOT_ACCUMULATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define BSDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsda assertion failed");

// next-cycle implication, disabled in reset
`define BSDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsda assertion failed");

`endif

// ----- rtl/core/bsda_pkg.sv -----
// Package for the block-scaled int8 dot accumulator: item types,
// float unit request type and shared constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsda_pkg;

    localparam int TILE_K_DEF = 64;
    localparam int FP_INT_W   = 24;   // integer tile sum width into the float unit
    localparam int FP_M_W     = 52;   // unrounded mantissa width
    localparam int FP_E_W     = 11;   // unrounded exponent width
    localparam int FP_S_W     = 12;   // normalize shift width

    typedef struct packed {
        logic signed [7:0] x_val;
        logic signed [7:0] w_val;
        logic [31:0]       x_scale;
        logic [31:0]       w_scale;
        logic [31:0]       bias_val;
        logic              k_last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] y_value;
    } t_out_item;

    typedef struct packed {
        logic bias_enable;
    } t_cfg_item;

    typedef enum logic [1:0] {
        FP_MUL = 2'd0,
        FP_ADD = 2'd1,
        FP_CVT = 2'd2
    } t_fp_op;

    typedef struct packed {
        t_fp_op                      op;
        logic [31:0]                 a;
        logic [31:0]                 b;
        logic signed [FP_INT_W-1:0]  ival;
    } t_fp_req;

endpackage

`default_nettype wire

// ----- rtl/core/bsda_stream_if.sv -----
// Valid/ready channel carrying one item of payload type T.
// Used for the input, output and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface bsda_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bsda_fp_unit.sv -----
// Shared fp32 unit: multiply, add and int-to-float, three-stage pipeline
// (operand prep, leading-one search, shift and round). Uses bsda_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsda_fp_unit
    import bsda_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire t_fp_req     i_req,
    output logic             o_done,
    output logic [31:0]      o_result
);

    logic        sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [7:0]  eea, eeb, ee_big, ee_small, d;
    logic [23:0] ma, mb, m_big, m_small;
    logic [47:0] prod;
    logic        a_big, s_big, sub;
    logic [5:0]  dd;
    logic [99:0] wide_small;
    logic [49:0] big50, aligned;
    logic [51:0] addend;
    logic [24:0] mag;

    logic                     f_sign, f_spec;
    logic signed [FP_E_W-1:0] f_e;
    logic [FP_M_W-1:0]        f_m;
    logic [31:0]              f_sbits;

    logic                     r_a_v, r_a_sign, r_a_spec;
    logic signed [FP_E_W-1:0] r_a_e;
    logic [FP_M_W-1:0]        r_a_m;
    logic [31:0]              r_a_sbits;

    logic                     r_b_v, r_b_sign, r_b_spec;
    logic signed [FP_E_W-1:0] r_b_e;
    logic signed [FP_S_W-1:0] r_b_s;
    logic [FP_M_W-1:0]        r_b_m;
    logic [31:0]              r_b_sbits;

    logic                     r_c_v;
    logic [31:0]              r_c_res;

    assign sa     = i_req.a[31];
    assign sb     = i_req.b[31];
    assign nan_a  = (i_req.a[30:23] == 8'hFF) && (i_req.a[22:0] != 23'd0);
    assign nan_b  = (i_req.b[30:23] == 8'hFF) && (i_req.b[22:0] != 23'd0);
    assign inf_a  = (i_req.a[30:23] == 8'hFF) && (i_req.a[22:0] == 23'd0);
    assign inf_b  = (i_req.b[30:23] == 8'hFF) && (i_req.b[22:0] == 23'd0);
    assign zero_a = (i_req.a[30:0] == 31'd0);
    assign zero_b = (i_req.b[30:0] == 31'd0);
    assign eea    = (i_req.a[30:23] == 8'd0) ? 8'd1 : i_req.a[30:23];
    assign eeb    = (i_req.b[30:23] == 8'd0) ? 8'd1 : i_req.b[30:23];
    assign ma     = {(i_req.a[30:23] != 8'd0), i_req.a[22:0]};
    assign mb     = {(i_req.b[30:23] != 8'd0), i_req.b[22:0]};
    assign prod   = ma * mb;

    // add alignment: larger magnitude kept, smaller shifted with sticky
    assign a_big      = (i_req.a[30:0] >= i_req.b[30:0]);
    assign s_big      = a_big ? sa : sb;
    assign ee_big     = a_big ? eea : eeb;
    assign ee_small   = a_big ? eeb : eea;
    assign m_big      = a_big ? ma : mb;
    assign m_small    = a_big ? mb : ma;
    assign sub        = sa ^ sb;
    assign d          = ee_big - ee_small;
    assign dd         = (d > 8'd60) ? 6'd60 : d[5:0];
    assign wide_small = {m_small, 76'd0} >> dd;
    assign aligned    = wide_small[99:50];
    assign big50      = {m_big, 26'd0};
    assign addend     = {2'b00, aligned[49:1], aligned[0] | (|wide_small[49:0])};
    assign mag        = i_req.ival[FP_INT_W-1]
                        ? (25'd0 - {i_req.ival[FP_INT_W-1], i_req.ival})
                        : {1'b0, i_req.ival};

    always_comb begin
        f_sign  = 1'b0;
        f_e     = '0;
        f_m     = '0;
        f_spec  = 1'b0;
        f_sbits = 32'd0;
        unique case (i_req.op)
            FP_MUL: begin
                f_sign = sa ^ sb;
                f_e    = $signed({3'b000, eea}) + $signed({3'b000, eeb}) - 11'sd300;
                f_m    = {4'd0, prod};
                if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
                    f_spec  = 1'b1;
                    f_sbits = 32'h7FC0_0000;
                end else if (inf_a || inf_b) begin
                    f_spec  = 1'b1;
                    f_sbits = {sa ^ sb, 8'hFF, 23'd0};
                end
            end
            FP_ADD: begin
                f_m    = sub ? ({2'b00, big50} - addend) : ({2'b00, big50} + addend);
                f_sign = (f_m == '0) ? (sa & sb) : s_big;
                f_e    = $signed({3'b000, ee_big}) - 11'sd176;
                if (nan_a || nan_b || (inf_a && inf_b && sub)) begin
                    f_spec  = 1'b1;
                    f_sbits = 32'h7FC0_0000;
                end else if (inf_a) begin
                    f_spec  = 1'b1;
                    f_sbits = {sa, 8'hFF, 23'd0};
                end else if (inf_b) begin
                    f_spec  = 1'b1;
                    f_sbits = {sb, 8'hFF, 23'd0};
                end
            end
            FP_CVT: begin
                f_sign = i_req.ival[FP_INT_W-1];
                f_m    = {27'd0, mag};
            end
            default: begin
                f_spec  = 1'b1;
                f_sbits = 32'h7FC0_0000;
            end
        endcase
    end

    // stage B: leading one and shift amount (subnormal floor)
    logic [5:0]               lead;
    logic signed [FP_S_W-1:0] s_hi, s_lo, s_sel;

    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < FP_M_W; i++) begin
            if (r_a_m[i]) begin
                lead = 6'(i);
            end
        end
        s_hi  = $signed({6'd0, lead}) - 12'sd23;
        s_lo  = -(FP_S_W'(r_a_e) + 12'sd149);
        s_sel = (s_hi > s_lo) ? s_hi : s_lo;
    end

    // stage C: shift, round to nearest even, pack
    logic [5:0]   sh;
    logic [115:0] wide_m;
    logic [24:0]  q25, q_l;
    logic [23:0]  qn;
    logic [4:0]   lsh;
    logic signed [12:0] ex;
    logic [31:0]  pack;

    always_comb begin
        sh     = (r_b_s > 12'sd60) ? 6'd60 : r_b_s[5:0];
        wide_m = {r_b_m, 64'd0} >> sh;
        lsh    = r_b_s[4:0];
        lsh    = 5'd0 - lsh;
        q_l    = 25'(r_b_m << lsh);
        if (r_b_s > 12'sd0) begin
            q25 = wide_m[88:64] + {24'd0, wide_m[63] & ((|wide_m[62:0]) | wide_m[64])};
        end else begin
            q25 = q_l;
        end
        ex = 13'(r_b_e) + 13'(r_b_s) + 13'sd150;
        if (q25[24]) begin
            qn = q25[24:1];
            ex = ex + 13'sd1;
        end else begin
            qn = q25[23:0];
        end
        if (!qn[23]) begin
            pack = {r_b_sign, 8'd0, qn[22:0]};
        end else if (ex >= 13'sd255) begin
            pack = {r_b_sign, 8'hFF, 23'd0};
        end else begin
            pack = {r_b_sign, ex[7:0], qn[22:0]};
        end
        if (r_b_spec) begin
            pack = r_b_sbits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_a_v <= i_start;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
        r_a_sign  <= f_sign;
        r_a_e     <= f_e;
        r_a_m     <= f_m;
        r_a_spec  <= f_spec;
        r_a_sbits <= f_sbits;
        r_b_sign  <= r_a_sign;
        r_b_e     <= r_a_e;
        r_b_m     <= r_a_m;
        r_b_s     <= s_sel;
        r_b_spec  <= r_a_spec;
        r_b_sbits <= r_a_sbits;
        r_c_res   <= pack;
    end

    assign o_done   = r_c_v;
    assign o_result = r_c_res;

endmodule

`default_nettype wire

// ----- rtl/core/int8_block_scaled_dot_accumulator.sv -----
// Top level of the block-scaled int8 dot accumulator: sequencer, tile
// state and bf16 output. Uses bsda_pkg, bsda_stream_if and bsda_fp_unit.
`timescale 1ns / 1ps
`default_nettype none
`include "int8_block_scaled_dot_accumulator_macros.svh"

// An item that does not close a tile only adds its int8 product to the tile
// sum, and the block stays ready for the next item. An item that closes a
// tile (TILE_K items taken, or k_last) runs four operations through the
// shared three-stage fp32 unit (convert, scale by x_scale, scale by w_scale,
// accumulate), one at a time, and takes no input meanwhile; with k_last and
// bias enabled one more add follows, and with k_last the bf16 result is then
// loaded into the output register. The output register holds a result until
// taken, and the next item may enter meanwhile.
module int8_block_scaled_dot_accumulator
    import bsda_pkg::*;
#(
    parameter int TILE_K = TILE_K_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    bsda_stream_if.sink    i_in,
    bsda_stream_if.sink    i_cfg,
    bsda_stream_if.source  o_out
);

    localparam int POS_W = (TILE_K > 1) ? $clog2(TILE_K) : 1;
    localparam int SUM_W = 16 + $clog2(TILE_K);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CVT  = 7'b0000010,
        S_MULX = 7'b0000100,
        S_MULW = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_BIAS = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                   r_state, n_state;
    logic                     r_issued;
    logic signed [SUM_W-1:0]  r_tile_sum;
    logic [POS_W-1:0]         r_tile_pos;
    logic                     r_bias_en, r_last, r_out_valid;
    logic [31:0]              r_xs, r_ws, r_bias, r_val, r_acc;
    logic [15:0]              r_y;

    logic                     w_in_acc, w_close, w_start, w_done, w_out_load, w_busy;
    logic signed [15:0]       w_prod;
    logic signed [SUM_W-1:0]  w_sum_new;
    logic [31:0]              w_res;
    t_fp_req                  w_req;

    function automatic logic [15:0] f_bf16(input logic [31:0] u);
        logic [31:0] t;
        t = u + 32'h0000_7FFF + {31'd0, u[16]};
        if ((u[30:23] == 8'hFF) && (u[22:0] != 23'd0)) begin
            return 16'h7FC0;
        end
        return t[31:16];
    endfunction

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid & i_in.ready;
    assign w_prod      = i_in.data.x_val * i_in.data.w_val;
    assign w_sum_new   = r_tile_sum + SUM_W'(w_prod);
    assign w_close     = (({1'b0, r_tile_pos} + (POS_W+1)'(1)) >= (POS_W+1)'(TILE_K))
                         || i_in.data.k_last;
    assign w_busy      = (r_state == S_CVT) || (r_state == S_MULX) || (r_state == S_MULW)
                         || (r_state == S_ACC) || (r_state == S_BIAS);
    assign w_start     = w_busy && !r_issued;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        w_req.op   = FP_ADD;
        w_req.a    = r_acc;
        w_req.b    = r_val;
        w_req.ival = FP_INT_W'(r_tile_sum);
        unique case (r_state)
            S_CVT:  w_req.op = FP_CVT;
            S_MULX: begin
                w_req.op = FP_MUL;
                w_req.a  = r_val;
                w_req.b  = r_xs;
            end
            S_MULW: begin
                w_req.op = FP_MUL;
                w_req.a  = r_val;
                w_req.b  = r_ws;
            end
            S_BIAS: w_req.b = r_bias;
            default: w_req.op = FP_ADD;
        endcase
    end

    bsda_fp_unit u_fp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_req    (w_req),
        .o_done   (w_done),
        .o_result (w_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc && w_close) n_state = S_CVT;
            S_CVT:  if (w_done) n_state = S_MULX;
            S_MULX: if (w_done) n_state = S_MULW;
            S_MULW: if (w_done) n_state = S_ACC;
            S_ACC: begin
                if (w_done) begin
                    n_state = !r_last ? S_IDLE : (r_bias_en ? S_BIAS : S_OUT);
                end
            end
            S_BIAS: if (w_done) n_state = S_OUT;
            S_OUT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_tile_sum  <= '0;
            r_tile_pos  <= '0;
            r_acc       <= 32'd0;
            r_bias_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_bias_en <= i_cfg.data.bias_enable;
            end
            if (w_start) begin
                r_issued <= 1'b1;
            end else if (w_done) begin
                r_issued <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc) begin
                r_tile_sum <= w_sum_new;
                r_tile_pos <= w_close ? '0 : r_tile_pos + POS_W'(1);
            end
            if (w_done) begin
                unique case (r_state)
                    S_CVT, S_MULX, S_MULW: r_val <= w_res;
                    S_ACC: begin
                        r_acc      <= w_res;
                        r_tile_sum <= '0;
                    end
                    default: r_acc <= w_res;
                endcase
            end
            if (w_out_load) begin
                r_acc <= 32'd0;
            end
        end
        if (w_in_acc) begin
            r_xs   <= i_in.data.x_scale;
            r_ws   <= i_in.data.w_scale;
            r_bias <= i_in.data.bias_val;
            r_last <= i_in.data.k_last;
        end
        if (w_out_load) begin
            r_y <= f_bf16(r_acc);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.data.y_value = r_y;

    `BSDA_ASSERT_NOW(a_done_issued, i_clk, i_rst_n, w_done, r_issued)
    `BSDA_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, 1'b1, ({1'b0, r_tile_pos} < (POS_W+1)'(TILE_K)))
    `BSDA_ASSERT_NXT(a_out_only_load, i_clk, i_rst_n, (!r_out_valid && !w_out_load), !r_out_valid)

endmodule

`default_nettype wire
